### rtl/assert_macros.svh
// Assertion helpers for the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define LOBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define LOBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/lobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int ORDER_SLOTS = 1024;
    localparam int GRP_SIZE    = 32;
    localparam int GRP_CNT     = ORDER_SLOTS / GRP_SIZE;
    localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
    localparam int PRICE_W     = 12;
    localparam int TRADE_CAP   = 63;
    localparam int TRADE_W     = 6;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_MATCH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_OWNER     = 3'd3,
        STS_FULL      = 3'd4
    } status_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TRADE  = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_GROUP,
        ST_DECIDE,
        ST_REMOVE,
        ST_INSERT,
        ST_STATUS,
        ST_MEVAL,
        ST_MUPD
    } state_t;

    typedef struct packed {
        logic               vld;
        logic               sd;
        logic [31:0]        id;
        logic [15:0]        own;
        logic [PRICE_W-1:0] prc;
        logic [31:0]        rem;
    } order_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic        ins;
        logic        ins_sd;
        order_t      item;
        logic [31:0] tq;
    } cell_ctl_t;

endpackage

### rtl/lobm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_cell
// One place of the order chain: holds one resting order and trades it with
// its neighbors on insert, removal and fill.
// ----------------------------------------------------------------------------
module lobm_cell
    import lobm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  logic      rmb_here,
    input  logic      rms_here,
    input  logic      dec_here,
    input  order_t    left,
    input  order_t    right,
    output order_t    q
);

    order_t cell_reg;
    order_t cell_next;
    logic   cb, cs, lb, ls, rb, rs;

    assign cb = cell_reg.vld && (cell_reg.sd == SIDE_BUY);
    assign cs = cell_reg.vld && (cell_reg.sd == SIDE_SELL);
    assign lb = left.vld && (left.sd == SIDE_BUY);
    assign ls = left.vld && (left.sd == SIDE_SELL);
    assign rb = right.vld && (right.sd == SIDE_BUY);
    assign rs = right.vld && (right.sd == SIDE_SELL);

    // Bids pack from the left end, best first; asks pack from the right end.
    always_comb begin
        cell_next = cell_reg;
        if (rmb_here && cb) begin
            cell_next = rb ? right : '0;
        end else if (rms_here && cs) begin
            cell_next = ls ? left : '0;
        end else if (dec_here) begin
            cell_next.rem = cell_reg.rem - ctl.tq;
        end else if (ctl.ins && ctl.ins_sd == SIDE_BUY && !cs) begin
            if (lb && left.prc < ctl.item.prc) begin
                cell_next = left;
            end else if ((!cell_reg.vld || (cb && cell_reg.prc < ctl.item.prc))
                         && lb && left.prc >= ctl.item.prc) begin
                cell_next = ctl.item;
            end
        end else if (ctl.ins && ctl.ins_sd == SIDE_SELL && !cb) begin
            if (rs && right.prc > ctl.item.prc) begin
                cell_next = right;
            end else if ((!cell_reg.vld || (cs && cell_reg.prc > ctl.item.prc))
                         && rs && right.prc <= ctl.item.prc) begin
                cell_next = ctl.item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule

### rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book with add, cancel, modify and match requests.
// ----------------------------------------------------------------------------
// Usage: a request enters on the s_ channel (valid/ready) and produces result
// items on the m_ channel (valid/ready). Every request ends with one status
// item with m_last high; a match request sends one trade record per fill
// before its status item.
// Orders live in a chain of cells: bids packed from the left end, best price
// first, and asks packed from the right end, so both best orders sit at the
// two fixed ends. Inserts and removals move cells by one place toward a
// neighbor.
// An add runs the id lookup, a decision, an insert and the status step; a
// cancel removes instead, a modify removes then inserts, and a rejected
// request goes from the decision to the status step. The lookup has three
// steps: per-cell compare, reduction over groups of 32 cells, final merge.
// A match loads then fills each trade, at most 63, before its status item.
// One request is worked on at a time; s_ready is high only between requests.
// The output register lets the next request enter while its status item
// still waits. A stalled receiver holds the block in its current step.
// Reset empties the book at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [31:0]        s_order_id,
    input  logic [15:0]        s_participant_id,
    input  logic               s_side,
    input  logic [PRICE_W-1:0] s_price,
    input  logic [31:0]        s_quantity,
    input  logic [31:0]        s_sequence_base,
    input  logic [47:0]        s_timestamp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [2:0]         m_status,
    output logic [31:0]        m_trade_sequence,
    output logic [47:0]        m_trade_timestamp,
    output logic [31:0]        m_buy_order_id,
    output logic [31:0]        m_sell_order_id,
    output logic [PRICE_W-1:0] m_trade_price,
    output logic [31:0]        m_trade_quantity,
    output logic [15:0]        m_buyer_id,
    output logic [15:0]        m_seller_id,
    output logic               m_last
);

`include "assert_macros.svh"

    localparam order_t SENT_L = '{vld: 1'b1, sd: SIDE_BUY, id: '0, own: '0,
                                  prc: '1, rem: '0};
    localparam order_t SENT_R = '{vld: 1'b1, sd: SIDE_SELL, id: '0, own: '0,
                                  prc: '0, rem: '0};

    state_t state_reg, state_next;

    // Request registers.
    cmd_t               cmd_reg;
    logic [31:0]        id_reg;
    logic [15:0]        own_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [31:0]        qty_reg;
    logic [31:0]        seq_reg;
    logic [47:0]        ts_reg;

    // Lookup pipeline.
    logic [ORDER_SLOTS-1:0] mvec_next, mvec_reg;
    logic [GRP_CNT-1:0]     gany_next, gany_reg;
    logic [GRP_CNT-1:0]     gsd_next, gsd_reg;
    logic [15:0]            gown_next [GRP_CNT];
    logic [15:0]            gown_reg  [GRP_CNT];
    logic [GRP_CNT-1:0]     gpre_next, gpre_reg, gsuf_next, gsuf_reg;
    logic                   found;
    logic [15:0]            found_own;
    logic                   found_sd;

    status_t            status_reg, status_next;
    logic               ins_sd_reg, ins_sd_next;
    logic               rm_sd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [TRADE_W-1:0] ntr_reg;
    logic [31:0]        tq_reg, tq_next;
    logic               zb_reg, zs_reg;

    // Output register.
    logic               m_valid_reg;
    logic               kind_reg;
    status_t            ostat_reg;
    logic [31:0]        oseq_reg;
    logic [47:0]        ots_reg;
    logic [31:0]        obid_reg, osid_reg;
    logic [PRICE_W-1:0] oprc_reg;
    logic [31:0]        oqty_reg;
    logic [15:0]        obuyer_reg, oseller_reg;
    logic               olast_reg;

    order_t    cell_q [ORDER_SLOTS];
    cell_ctl_t ctl;
    order_t    bid_head, ask_head;
    logic      can_trade, out_free;
    logic      load_status, load_trade, do_remove, do_insert, do_fill;

    assign bid_head = cell_q[0];
    assign ask_head = cell_q[ORDER_SLOTS-1];
    assign out_free = !m_valid_reg || m_ready;
    assign can_trade = bid_head.vld && (bid_head.sd == SIDE_BUY)
                    && ask_head.vld && (ask_head.sd == SIDE_SELL)
                    && (bid_head.prc >= ask_head.prc)
                    && (bid_head.own != ask_head.own)
                    && (ntr_reg != TRADE_W'(TRADE_CAP));
    assign tq_next = (bid_head.rem < ask_head.rem) ? bid_head.rem : ask_head.rem;

    // Per-cell id compare, group reductions and the final merge.
    always_comb begin
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            mvec_next[i] = cell_q[i].vld && (cell_q[i].id == id_reg);
        end
        for (int g = 0; g < GRP_CNT; g++) begin
            gany_next[g] = |mvec_reg[g*GRP_SIZE +: GRP_SIZE];
            gsd_next[g]  = 1'b0;
            gown_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                gsd_next[g]  = gsd_next[g] | (mvec_reg[g*GRP_SIZE+k] & cell_q[g*GRP_SIZE+k].sd);
                gown_next[g] = gown_next[g]
                             | ({16{mvec_reg[g*GRP_SIZE+k]}} & cell_q[g*GRP_SIZE+k].own);
            end
        end
        found     = |gany_reg;
        found_sd  = |gsd_reg;
        found_own = '0;
        for (int g = 0; g < GRP_CNT; g++) begin
            found_own = found_own | gown_reg[g];
        end
    end

    for (genvar g = 0; g < GRP_CNT; g++) begin : g_gmask
        localparam logic [GRP_CNT-1:0] BELOW = GRP_CNT'((64'd1 << g) - 64'd1);
        localparam logic [GRP_CNT-1:0] ABOVE = ~GRP_CNT'((64'd2 << g) - 64'd1);
        assign gpre_next[g] = |(gany_reg & BELOW);
        assign gsuf_next[g] = |(gany_reg & ABOVE);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (cmd_t'(s_command) == CMD_MATCH) ? ST_MEVAL : ST_LOOK;
                end
            end
            ST_LOOK:  state_next = ST_GROUP;
            ST_GROUP: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (cmd_reg == CMD_ADD) begin
                    if (found || count_reg == CNT_W'(ORDER_SLOTS)) begin
                        state_next = ST_STATUS;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end else if (!found || found_own != own_reg) begin
                    state_next = ST_STATUS;
                end else begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE: state_next = (cmd_reg == CMD_MODIFY) ? ST_INSERT : ST_STATUS;
            ST_INSERT: state_next = ST_STATUS;
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEVAL: begin
                if (out_free) begin
                    state_next = can_trade ? ST_MUPD : ST_IDLE;
                end
            end
            ST_MUPD: state_next = ST_MEVAL;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        load_status = 1'b0;
        load_trade  = 1'b0;
        do_remove   = 1'b0;
        do_insert   = 1'b0;
        do_fill     = 1'b0;
        status_next = status_reg;
        ins_sd_next = ins_sd_reg;
        unique case (state_reg)
            ST_DECIDE: begin
                if (cmd_reg == CMD_ADD) begin
                    ins_sd_next = side_reg;
                    if (found) begin
                        status_next = STS_DUPLICATE;
                    end else if (count_reg == CNT_W'(ORDER_SLOTS)) begin
                        status_next = STS_FULL;
                    end else begin
                        status_next = STS_OK;
                    end
                end else begin
                    ins_sd_next = found_sd;
                    if (!found) begin
                        status_next = STS_NOT_FOUND;
                    end else if (found_own != own_reg) begin
                        status_next = STS_OWNER;
                    end else begin
                        status_next = STS_OK;
                    end
                end
            end
            ST_REMOVE: do_remove = 1'b1;
            ST_INSERT: do_insert = 1'b1;
            ST_STATUS: load_status = out_free;
            ST_MEVAL: begin
                load_trade  = out_free && can_trade;
                load_status = out_free && !can_trade;
                status_next = STS_OK;
            end
            ST_MUPD: do_fill = 1'b1;
            default: ;
        endcase
    end

    assign ctl.ins         = do_insert;
    assign ctl.ins_sd      = ins_sd_reg;
    assign ctl.item.vld    = 1'b1;
    assign ctl.item.sd     = ins_sd_reg;
    assign ctl.item.id     = id_reg;
    assign ctl.item.own    = own_reg;
    assign ctl.item.prc    = price_reg;
    assign ctl.item.rem    = qty_reg;
    assign ctl.tq          = tq_reg;

    // The chain. A removal moves each order of its side behind the removed one
    // by one place toward the end where that side packs.
    for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
        localparam int G = i / GRP_SIZE;
        localparam int K = i % GRP_SIZE;
        localparam logic [GRP_SIZE-1:0] UPTO = GRP_SIZE'((64'd2 << K) - 64'd1);
        localparam logic [GRP_SIZE-1:0] FROM = ~GRP_SIZE'((64'd1 << K) - 64'd1);
        logic   pre, suf, rmb, rms, dec;
        order_t lft, rgt;

        assign pre = gpre_reg[G] | (|(mvec_reg[G*GRP_SIZE +: GRP_SIZE] & UPTO));
        assign suf = gsuf_reg[G] | (|(mvec_reg[G*GRP_SIZE +: GRP_SIZE] & FROM));
        assign rmb = (do_remove && rm_sd_reg == SIDE_BUY && pre) || (do_fill && zb_reg);
        assign rms = (do_remove && rm_sd_reg == SIDE_SELL && suf) || (do_fill && zs_reg);
        if (i == 0) begin : g_first
            assign lft = SENT_L;
            assign dec = do_fill && !zb_reg;
        end else begin : g_mid_l
            assign lft = cell_q[i-1];
            if (i == ORDER_SLOTS - 1) begin : g_last_dec
                assign dec = do_fill && !zs_reg;
            end else begin : g_no_dec
                assign dec = 1'b0;
            end
        end
        if (i == ORDER_SLOTS - 1) begin : g_last
            assign rgt = SENT_R;
        end else begin : g_mid_r
            assign rgt = cell_q[i+1];
        end

        lobm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .rmb_here (rmb),
            .rms_here (rms),
            .dec_here (dec),
            .left     (lft),
            .right    (rgt),
            .q        (cell_q[i])
        );
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_remove) begin
                count_reg <= count_reg - CNT_W'(1);
            end else if (do_fill) begin
                count_reg <= count_reg - CNT_W'(zb_reg) - CNT_W'(zs_reg);
            end
            if (load_status || load_trade) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            cmd_reg   <= cmd_t'(s_command);
            id_reg    <= s_order_id;
            own_reg   <= s_participant_id;
            side_reg  <= s_side;
            price_reg <= s_price;
            qty_reg   <= s_quantity;
            seq_reg   <= s_sequence_base;
            ts_reg    <= s_timestamp;
            ntr_reg   <= '0;
        end
        if (state_reg == ST_LOOK) begin
            mvec_reg <= mvec_next;
        end
        if (state_reg == ST_GROUP) begin
            gany_reg <= gany_next;
            gsd_reg  <= gsd_next;
            gown_reg <= gown_next;
        end
        if (state_reg == ST_DECIDE) begin
            gpre_reg  <= gpre_next;
            gsuf_reg  <= gsuf_next;
            rm_sd_reg <= found_sd;
        end
        status_reg <= status_next;
        ins_sd_reg <= ins_sd_next;
        if (load_trade) begin
            tq_reg      <= tq_next;
            zb_reg      <= (bid_head.rem == tq_next);
            zs_reg      <= (ask_head.rem == tq_next);
            ntr_reg     <= ntr_reg + TRADE_W'(1);
            kind_reg    <= KIND_TRADE;
            ostat_reg   <= STS_OK;
            oseq_reg    <= seq_reg + 32'(ntr_reg);
            ots_reg     <= ts_reg;
            obid_reg    <= bid_head.id;
            osid_reg    <= ask_head.id;
            oprc_reg    <= ask_head.prc;
            oqty_reg    <= tq_next;
            obuyer_reg  <= bid_head.own;
            oseller_reg <= ask_head.own;
            olast_reg   <= 1'b0;
        end else if (load_status) begin
            kind_reg    <= KIND_STATUS;
            ostat_reg   <= status_next;
            oseq_reg    <= '0;
            ots_reg     <= '0;
            obid_reg    <= '0;
            osid_reg    <= '0;
            oprc_reg    <= '0;
            oqty_reg    <= '0;
            obuyer_reg  <= '0;
            oseller_reg <= '0;
            olast_reg   <= 1'b1;
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_kind            = kind_reg;
    assign m_status          = ostat_reg;
    assign m_trade_sequence  = oseq_reg;
    assign m_trade_timestamp = ots_reg;
    assign m_buy_order_id    = obid_reg;
    assign m_sell_order_id   = osid_reg;
    assign m_trade_price     = oprc_reg;
    assign m_trade_quantity  = oqty_reg;
    assign m_buyer_id        = obuyer_reg;
    assign m_seller_id       = oseller_reg;
    assign m_last            = olast_reg;

    // One side reaches the opposite end of the chain only when it fills the whole store.
    `LOBM_ASSERT(a_head_sides, ((bid_head.vld && bid_head.sd == SIDE_SELL) || (ask_head.vld && ask_head.sd == SIDE_BUY)) |-> (count_reg == CNT_W'(ORDER_SLOTS)), "book side crosses the chain end")
    // The order count stays within the store.
    `LOBM_ASSERT_ALWAYS(a_count_range, (!aresetn || count_reg <= CNT_W'(ORDER_SLOTS)), "order count out of range")
    // A fill step always follows a trade record being loaded.
    `LOBM_ASSERT(a_fill_after_trade, (state_reg == ST_MUPD) |-> $past(load_trade), "fill without trade")
    // A trade record never carries the last flag.
    `LOBM_ASSERT(a_trade_not_last, load_trade |=> (m_kind == KIND_TRADE && !m_last), "trade marked last")

endmodule
